// File: hw/rtl/scpc_pkg.sv
// Package for the stripe-count position correction block.
// Holds the word types, configuration register codes, sequencer states and
// shared constants. No dependencies.
`default_nettype none

package scpc_pkg;

	localparam int NUM_SENSORS     = 2;
	localparam int CARRIED_SENSORS = 2;

	localparam logic [31:0] STRIPE_GAP_US = 32'd100000;
	localparam logic [31:0] US_PER_S      = 32'd1000000;
	// Largest first quotient that can still give a rate below the cap.
	localparam logic [51:0] RATE_Q_MAX    = 52'd1099511;
	localparam logic [40:0] RATE_CAP      = 41'h100_0000_0000;
	localparam logic [30:0] MASK31        = 31'h7FFF_FFFF;
	localparam logic [30:0] RESET_SPACING = 31'd1997537;
	// ceil(2^34 / 5): the product shifted right by 34 is the exact quotient
	// by five for any 32-bit operand.
	localparam logic [31:0] DIV5_RECIP    = 32'hCCCC_CCCD;

	localparam int ERR_W  = 50;
	localparam int DIV_N  = 52;
	localparam int DIV_D  = 32;
	localparam int DIV_CW = $clog2(DIV_N);

	typedef enum logic [1:0] {
		REG_SPACING  = 2'd0,
		REG_POS_UNC  = 2'd1,
		REG_START    = 2'd2,
		REG_VU_START = 2'd3
	} cfg_reg_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SCAN, ST_POS, ST_ERR, ST_S5, ST_S5W, ST_MISS, ST_FCHK,
		ST_FW, ST_RATE, ST_RQW, ST_RCHK, ST_RQM, ST_RREM, ST_R2W, ST_RDONE,
		ST_POS2, ST_ERR2, ST_FIN
	} state_t;

	typedef struct packed {
		logic signed [31:0] displacement;
		logic signed [31:0] velocity;
		logic               real_run;
		logic [31:0]        current_time;
		logic [31:0]        sensor_a_count;
		logic [31:0]        sensor_a_time;
		logic [31:0]        sensor_b_count;
		logic [31:0]        sensor_b_time;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] displacement_out;
		logic signed [31:0] velocity_out;
		logic               stripe_seen;
		logic [15:0]        stripes;
		logic [7:0]         failures;
		logic               critical_failure;
		logic [30:0]        velocity_uncertainty;
	} out_item_t;

	typedef struct packed {
		logic             start;
		logic [DIV_N-1:0] dividend;
		logic [DIV_D-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_N-1:0] quotient;
		logic [DIV_D-1:0] remainder;
	} div_rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/scpc_if.sv
// Valid/ready channel interfaces for the input query and the result word.
// Depends on scpc_pkg for the payload types.
`default_nettype none

interface scpc_in_if;
	logic                valid;
	logic                ready;
	scpc_pkg::in_item_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface scpc_out_if;
	logic                valid;
	logic                ready;
	scpc_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/scpc_div.sv
// Shared restoring divider: one quotient bit per cycle.
// Depends on scpc_pkg.
`default_nettype none

module scpc_div (
	input  wire               clk,
	input  wire               arst_n,
	input  scpc_pkg::div_req_t req,
	output scpc_pkg::div_rsp_t rsp
);
	import scpc_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_N-1:0]  dvd_q;
	logic [DIV_D-1:0]  rem_q;
	logic [DIV_D-1:0]  dvs_q;
	logic [DIV_D:0]    trial;
	logic [DIV_D:0]    diff;
	logic              ge;

	always_comb begin
		trial = {rem_q, dvd_q[DIV_N-1]};
		ge    = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CW'(DIV_N - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_N-2:0], ge};
			rem_q <= ge ? diff[DIV_D-1:0] : trial[DIV_D-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = dvd_q;
	assign rsp.remainder = rem_q;

endmodule

`default_nettype wire

// File: hw/rtl/stripe_count_position_correction.sv
// Stripe-count position correction: snaps displacement to the stripe grid and
// corrects velocity. Depends on scpc_pkg, scpc_if and scpc_div.
//
// One query at a time. A query that counts no stripe skips the sequencer. A
// query that counts a stripe runs a small sequencer around one shared divider
// and one shared multiplier: spacing/5 by a reciprocal multiply, an optional
// error/spacing division, and one or two rate computations of up to two
// divisions each; a zero time divisor skips the rate divisions. The result
// sits in an output register, so a new query is taken while it waits.
`default_nettype none

module stripe_count_position_correction (
	input  wire        clk,
	input  wire        arst_n,
	scpc_in_if.sink    in_ch,
	scpc_out_if.source out_ch,
	input  wire        cfg_we,
	input  wire [1:0]  cfg_index,
	input  wire [31:0] cfg_data
);
	import scpc_pkg::*;

	state_t state_q, state_d;

	logic [30:0] s_q, pu_q, vu_q;
	logic [31:0] st_q, last_q, dt_q;
	logic [15:0] total_q;
	logic [7:0]  fail_q;
	logic [31:0] prev_q [CARRIED_SENSORS];

	in_item_t    in_q;
	logic        seen_q, pass2_q;
	logic [47:0] pos_q;
	logic [63:0] mul_q;
	logic [30:0] allowed_q;
	logic signed [ERR_W-1:0] err_q, rate_e_q;
	logic [51:0] rq_q;
	logic [31:0] rr_q;
	logic [40:0] qm_q, mag_q;

	out_item_t   out_q;
	logic        out_valid_q;

	div_req_t    dreq;
	div_rsp_t    drsp;

	logic [31:0] mul_a, mul_b;
	logic [31:0] cnts [CARRIED_SENSORS];
	logic [31:0] tims [CARRIED_SENSORS];
	logic        hit;
	logic [31:0] hit_t;
	logic        in_acc, slot_free;
	logic [15:0] total_inc;
	logic signed [ERR_W-1:0] d_e, s_e, a_e, e_new;
	logic [48:0] abs_err, abs_rate_e;
	logic        miss_ok, outside;
	logic [9:0]  fail_sum;
	logic [7:0]  fail_inc;
	logic [41:0] rate_sum;
	logic [30:0] mag_c;
	logic signed [31:0] vu_diff;
	logic signed [42:0] rate_s, v_new;
	logic signed [31:0] d_out, v_out;
	logic signed [50:0] crit_l, crit_r;

	scpc_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign in_acc    = in_ch.valid && in_ch.ready;
	assign slot_free = !out_valid_q || out_ch.ready;
	assign total_inc = (total_q == 16'hFFFF) ? total_q : total_q + 16'd1;

	always_comb begin
		cnts[0] = in_q.sensor_a_count;
		tims[0] = in_q.sensor_a_time;
		cnts[1] = in_q.sensor_b_count;
		tims[1] = in_q.sensor_b_time;
		hit   = 1'b0;
		hit_t = '0;
		for (int i = 0; i < NUM_SENSORS && i < CARRIED_SENSORS; i++) begin
			if (!hit && cnts[i] != prev_q[i] && (tims[i] - last_q) > STRIPE_GAP_US) begin
				hit   = 1'b1;
				hit_t = in_q.real_run ? tims[i] : in_q.current_time;
			end
		end
	end

	always_comb begin
		d_e        = ERR_W'(in_q.displacement);
		s_e        = $signed(ERR_W'(s_q));
		a_e        = $signed(ERR_W'(allowed_q));
		e_new      = d_e - $signed({2'b00, mul_q[47:0]});
		abs_err    = err_q[ERR_W-1] ? 49'(-err_q) : err_q[48:0];
		abs_rate_e = rate_e_q[ERR_W-1] ? 49'(-rate_e_q) : rate_e_q[48:0];
		miss_ok    = (err_q > s_e - a_e) && (err_q < s_e + a_e) && ((err_q <<< 1) > s_e);
		outside    = {1'b0, abs_err} > {18'b0, allowed_q, 1'b0};
		fail_inc   = (|drsp.quotient[51:8]) ? 8'hFF : drsp.quotient[7:0];
		fail_sum   = {2'b00, fail_q} + 10'd1 + {2'b00, fail_inc};
		rate_sum   = {1'b0, qm_q} + {1'b0, drsp.quotient[40:0]};
		mag_c      = (mag_q > {10'b0, MASK31}) ? MASK31 : mag_q[30:0];
		vu_diff    = $signed({1'b0, vu_q}) - $signed({1'b0, mag_c});
		rate_s     = rate_e_q[ERR_W-1] ? -$signed({2'b00, mag_q}) : $signed({2'b00, mag_q});
		v_new      = 43'(in_q.velocity) - rate_s;
		if (!seen_q) begin
			d_out = in_q.displacement;
			v_out = in_q.velocity;
		end else begin
			d_out = (pos_q > 48'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(pos_q[31:0]);
			if (v_new > 43'sh7FFF_FFFF)
				v_out = 32'sh7FFF_FFFF;
			else if (v_new < -43'sh8000_0000)
				v_out = -32'sh8000_0000;
			else
				v_out = v_new[31:0];
		end
		crit_l = 51'(d_out) - $signed({3'b000, pos_q});
		crit_r = $signed({18'b0, s_q, 2'b00});
	end

	// Shared multiplier operands.
	always_comb begin
		mul_a = {16'b0, total_q};
		mul_b = {1'b0, s_q};
		unique case (state_q)
			ST_S5: begin
				mul_a = {1'b0, s_q};
				mul_b = DIV5_RECIP;
			end
			ST_RCHK: begin
				mul_a = rq_q[31:0];
				mul_b = US_PER_S;
			end
			ST_RQM: begin
				mul_a = rr_q;
				mul_b = US_PER_S;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d       = state_q;
		in_ch.ready   = 1'b0;
		dreq.start    = 1'b0;
		dreq.dividend = 52'(abs_rate_e);
		dreq.divisor  = dt_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) state_d = ST_SCAN;
			end
			ST_SCAN: state_d = ST_POS;
			ST_POS:  state_d = ST_ERR;
			ST_ERR:  state_d = seen_q ? ST_S5 : ST_FIN;
			ST_S5:   state_d = ST_S5W;
			ST_S5W:  state_d = ST_MISS;
			ST_MISS: state_d = ST_FCHK;
			ST_FCHK: begin
				if (outside && s_q != '0) begin
					dreq.start    = 1'b1;
					dreq.dividend = 52'(abs_err);
					dreq.divisor  = {1'b0, s_q};
					state_d       = ST_FW;
				end else begin
					state_d = ST_RATE;
				end
			end
			ST_FW:   if (drsp.done) state_d = ST_RATE;
			ST_RATE: begin
				if (dt_q == '0) begin
					state_d = ST_RDONE;
				end else begin
					dreq.start = 1'b1;
					state_d    = ST_RQW;
				end
			end
			ST_RQW:  if (drsp.done) state_d = ST_RCHK;
			ST_RCHK: state_d = (rq_q > RATE_Q_MAX) ? ST_RDONE : ST_RQM;
			ST_RQM:  state_d = ST_RREM;
			ST_RREM: begin
				dreq.start    = 1'b1;
				dreq.dividend = mul_q[51:0];
				state_d       = ST_R2W;
			end
			ST_R2W:   if (drsp.done) state_d = ST_RDONE;
			ST_RDONE: state_d = pass2_q ? ST_FIN : ST_POS2;
			ST_POS2:  state_d = ST_ERR2;
			ST_ERR2:  state_d = (e_new != rate_e_q) ? ST_RATE : ST_FIN;
			ST_FIN:   if (slot_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Configuration and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q     <= RESET_SPACING;
			pu_q    <= '0;
			st_q    <= '0;
			vu_q    <= '0;
			total_q <= '0;
			last_q  <= '0;
			fail_q  <= '0;
			for (int i = 0; i < CARRIED_SENSORS; i++) prev_q[i] <= '0;
		end else begin
			unique case (state_q)
				ST_SCAN: begin
					for (int i = 0; i < CARRIED_SENSORS; i++) prev_q[i] <= cnts[i];
					if (hit) begin
						total_q <= total_inc;
						last_q  <= hit_t;
					end
				end
				ST_MISS: if (miss_ok) total_q <= total_inc;
				ST_FCHK: if (outside && s_q == '0) fail_q <= 8'hFF;
				ST_FW: begin
					if (drsp.done) fail_q <= (fail_sum > 10'd255) ? 8'hFF : fail_sum[7:0];
				end
				ST_RDONE: begin
					if (!pass2_q) vu_q <= vu_diff[31] ? 31'(-vu_diff) : vu_diff[30:0];
				end
				default: ;
			endcase
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_SPACING:  s_q  <= cfg_data[30:0];
					REG_POS_UNC:  pu_q <= cfg_data[30:0];
					REG_START:    st_q <= cfg_data;
					REG_VU_START: vu_q <= cfg_data[30:0];
					default: ;
				endcase
			end
		end
	end

	// Working registers of the sequencer.
	always_ff @(posedge clk) begin
		mul_q <= 64'(mul_a) * 64'(mul_b);
		unique case (state_q)
			ST_IDLE: if (in_acc) in_q <= in_ch.data;
			ST_SCAN: begin
				seen_q <= hit;
				dt_q   <= hit_t - st_q;
			end
			ST_ERR: begin
				pos_q <= mul_q[47:0];
				err_q <= e_new;
			end
			ST_S5W: begin
				allowed_q <= (pu_q < {1'b0, mul_q[63:34]}) ? {1'b0, mul_q[63:34]} : pu_q;
			end
			ST_MISS: if (miss_ok) err_q <= err_q - s_e;
			ST_FCHK: begin
				rate_e_q <= err_q;
				pass2_q  <= 1'b0;
			end
			ST_RATE: if (dt_q == '0) mag_q <= '0;
			ST_RQW: begin
				if (drsp.done) begin
					rq_q <= drsp.quotient;
					rr_q <= drsp.remainder;
				end
			end
			ST_RCHK: if (rq_q > RATE_Q_MAX) mag_q <= RATE_CAP;
			ST_RQM:  qm_q <= mul_q[40:0];
			ST_R2W: begin
				if (drsp.done)
					mag_q <= (rate_sum > {1'b0, RATE_CAP}) ? RATE_CAP : rate_sum[40:0];
			end
			ST_ERR2: begin
				pos_q <= mul_q[47:0];
				if (e_new != rate_e_q) begin
					rate_e_q <= e_new;
					pass2_q  <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && slot_free) begin
			out_q.displacement_out     <= d_out;
			out_q.velocity_out         <= v_out;
			out_q.stripe_seen          <= seen_q;
			out_q.stripes              <= total_q;
			out_q.failures             <= fail_q;
			out_q.critical_failure     <= (fail_q > 8'd1) || (crit_l > crit_r);
			out_q.velocity_uncertainty <= vu_q;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

endmodule

`default_nettype wire

// File: hw/rtl/scpc_chk.sv
// Port-level checker for the stripe-count position correction block, bound
// to the top level. Depends on scpc_pkg.
`default_nettype none

module scpc_chk (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 in_valid,
	input wire                 in_ready,
	input wire                 out_valid,
	input wire                 out_ready,
	input scpc_pkg::out_item_t out_data
);
	import scpc_pkg::*;

	// A stalled result word must hold.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// One query at a time: no second word is taken right after one.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a query is in work");

	a_crit_on_failures: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.failures > 8'd1 |-> out_data.critical_failure)
		else $error("critical flag missing with several failures");

	// A counted stripe snaps displacement onto the non-negative grid.
	a_snap_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.stripe_seen |-> !out_data.displacement_out[31])
		else $error("snapped displacement is negative");

endmodule

bind stripe_count_position_correction scpc_chk u_scpc_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_ch.valid),
	.in_ready (in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_data (out_ch.data)
);

`default_nettype wire
